@@ src/fra_pkg.sv @@
// ----------------------------------------------------------------------------
// fra_pkg
// Shared widths, datapath operation codes and the command/status bundles
// that join the fraction adder controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

  // Operand word width (two's complement input fields)
  localparam int unsigned VALUE_BITS = 16;
  // Magnitude of a strictly positive operand
  localparam int unsigned MAG_W      = VALUE_BITS - 1;
  // Unreduced product and sum widths
  localparam int unsigned DEN_W      = 2 * VALUE_BITS - 2;
  localparam int unsigned NUM_W      = 2 * VALUE_BITS - 1;
  // Step counter covers one bit per divider step
  localparam int unsigned CNT_W      = $clog2(NUM_W);

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_STRIP,
    OP_GCD,
    OP_DIVN,
    OP_DIVD
  } fra_op_e;

  typedef struct packed {
    fra_op_e op;
  } fra_cmd_t;

  typedef struct packed {
    logic empty;      // an operand was zero or negative
    logic both_even;  // gcd operands share a factor of two
    logic gcd_done;   // gcd operands have met
  } fra_status_t;

endpackage

`default_nettype wire

@@ src/fraction_add_reduce.sv @@
// Sequence: a load, then straight to the result strobe when an operand is
//   empty; otherwise 1 load, 4 multiply, up to 28 common-two strips, binary
//   gcd steps until the operands meet, then 2 x 31 restoring divider steps.
// Throughput: one request at a time; busy stays high until the result strobe.
// The result strobe is one cycle wide and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two positive fractions and returns the sum reduced by its gcd.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_add_reduce (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  lhs_numerator_i,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  lhs_denominator_i,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  rhs_numerator_i,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  rhs_denominator_i,
  output logic                                 result_valid_o,
  output logic [fra_pkg::NUM_W-1:0]            sum_numerator_o,
  output logic [fra_pkg::DEN_W-1:0]            sum_denominator_o,
  output logic                                 empty_result_o
);

  fra_pkg::fra_cmd_t    cmd;
  fra_pkg::fra_status_t status;

  // Sequencer
  fra_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .status_i       (status),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  // Arithmetic
  fra_datapath u_datapath (
    .clk_i             (clk_i),
    .lhs_numerator_i   (lhs_numerator_i),
    .lhs_denominator_i (lhs_denominator_i),
    .rhs_numerator_i   (rhs_numerator_i),
    .rhs_denominator_i (rhs_denominator_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .sum_numerator_o   (sum_numerator_o),
    .sum_denominator_o (sum_denominator_o),
    .empty_result_o    (empty_result_o)
  );

endmodule

`default_nettype wire

@@ src/fra_datapath.sv @@
// ----------------------------------------------------------------------------
// fra_datapath
// Operand registers, one shared multiplier, a binary gcd unit and a
// restoring divider that reduces numerator and denominator in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_datapath (
  input  wire                                  clk_i,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  lhs_numerator_i,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  lhs_denominator_i,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  rhs_numerator_i,
  input  wire logic [fra_pkg::VALUE_BITS-1:0]  rhs_denominator_i,
  input  wire fra_pkg::fra_cmd_t               cmd_i,
  output fra_pkg::fra_status_t                 status_o,
  output logic [fra_pkg::NUM_W-1:0]            sum_numerator_o,
  output logic [fra_pkg::DEN_W-1:0]            sum_denominator_o,
  output logic                                 empty_result_o
);

  localparam int unsigned VB  = fra_pkg::VALUE_BITS;
  localparam int unsigned MW  = fra_pkg::MAG_W;
  localparam int unsigned NW  = fra_pkg::NUM_W;
  localparam int unsigned DW  = fra_pkg::DEN_W;

  logic [MW-1:0] a_q, b_q, c_q, d_q;
  logic [MW-1:0] a_d, b_d, c_d, d_d;
  logic          empty_q;
  logic [DW-1:0] prod_q;
  logic [NW-1:0] n_q, q_q, x_q, y_q, r_q;

  logic [MW-1:0] mul_a, mul_b;
  logic [DW-1:0] mul_p;
  logic [NW-1:0] sum_w;
  logic [NW-1:0] div_src;
  logic [NW:0]   rem_sh;
  logic          rem_ge;
  logic [NW-1:0] rem_nx;
  logic [NW-1:0] quo_nx;

  // Keep only strictly positive operands; a set sign bit reads as zero
  assign a_d = lhs_numerator_i[VB-1]   ? '0 : lhs_numerator_i[MW-1:0];
  assign b_d = lhs_denominator_i[VB-1] ? '0 : lhs_denominator_i[MW-1:0];
  assign c_d = rhs_numerator_i[VB-1]   ? '0 : rhs_numerator_i[MW-1:0];
  assign d_d = rhs_denominator_i[VB-1] ? '0 : rhs_denominator_i[MW-1:0];

  // Select multiplier operands for the current product
  always_comb begin
    case (cmd_i.op)
      fra_pkg::OP_MUL1: begin
        mul_a = b_q;
        mul_b = c_q;
      end
      fra_pkg::OP_MUL2: begin
        mul_a = b_q;
        mul_b = d_q;
      end
      default: begin
        mul_a = a_q;
        mul_b = d_q;
      end
    endcase
  end

  assign mul_p = DW'(mul_a * mul_b);
  assign sum_w = NW'(n_q) + NW'(prod_q);

  // One restoring divider step on the selected dividend
  assign div_src = (cmd_i.op == fra_pkg::OP_DIVD) ? q_q : n_q;
  assign rem_sh  = {r_q, div_src[NW-1]};
  assign rem_ge  = rem_sh >= {1'b0, x_q};
  assign rem_nx  = rem_ge ? NW'(rem_sh - {1'b0, x_q}) : rem_sh[NW-1:0];
  assign quo_nx  = {div_src[NW-2:0], rem_ge};

  // Advance the datapath under controller command
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      fra_pkg::OP_LOAD: begin
        a_q     <= a_d;
        b_q     <= b_d;
        c_q     <= c_d;
        d_q     <= d_d;
        empty_q <= (a_d == '0) || (b_d == '0) || (c_d == '0) || (d_d == '0);
        n_q     <= '0;
        q_q     <= '0;
        r_q     <= '0;
      end
      fra_pkg::OP_MUL0: begin
        prod_q <= mul_p;
      end
      fra_pkg::OP_MUL1: begin
        n_q    <= NW'(prod_q);
        prod_q <= mul_p;
      end
      fra_pkg::OP_MUL2: begin
        n_q    <= sum_w;
        prod_q <= mul_p;
      end
      fra_pkg::OP_MUL3: begin
        q_q <= NW'(prod_q);
        x_q <= n_q;
        y_q <= NW'(prod_q);
      end
      fra_pkg::OP_STRIP: begin
        // drop a common factor of two from all four values
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        n_q <= n_q >> 1;
        q_q <= q_q >> 1;
      end
      fra_pkg::OP_GCD: begin
        if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q > y_q) begin
          x_q <= x_q - y_q;
        end else begin
          y_q <= y_q - x_q;
        end
        r_q <= '0;
      end
      fra_pkg::OP_DIVN: begin
        r_q <= rem_nx;
        n_q <= quo_nx;
      end
      fra_pkg::OP_DIVD: begin
        r_q <= rem_nx;
        q_q <= quo_nx;
      end
      default: begin
      end
    endcase
  end

  assign status_o.empty     = empty_q;
  assign status_o.both_even = !x_q[0] && !y_q[0];
  assign status_o.gcd_done  = (x_q == y_q);

  assign sum_numerator_o   = n_q;
  assign sum_denominator_o = q_q[DW-1:0];
  assign empty_result_o    = empty_q;

endmodule

`default_nettype wire

@@ src/fra_ctrl.sv @@
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer for the fraction adder: load, three products, binary gcd,
// then two restoring divisions, and a one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  wire fra_pkg::fra_status_t  status_i,
  output fra_pkg::fra_cmd_t          cmd_o,
  output logic                       result_valid_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_STRIP = 3'd2;
  localparam logic [2:0] S_GCD   = 3'd3;
  localparam logic [2:0] S_DIVN  = 3'd4;
  localparam logic [2:0] S_DIVD  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int unsigned CW = fra_pkg::CNT_W;
  localparam logic [CW-1:0] DIV_LAST = CW'(fra_pkg::NUM_W - 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(3);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Next state and datapath command
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = fra_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = fra_pkg::OP_LOAD;
          cnt_d    = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (status_i.empty) begin
          state_d = S_DONE;
        end else begin
          case (cnt_q[1:0])
            2'd0:    cmd_o.op = fra_pkg::OP_MUL0;
            2'd1:    cmd_o.op = fra_pkg::OP_MUL1;
            2'd2:    cmd_o.op = fra_pkg::OP_MUL2;
            default: cmd_o.op = fra_pkg::OP_MUL3;
          endcase
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_d = S_STRIP;
          end
        end
      end
      S_STRIP: begin
        if (status_i.both_even) begin
          cmd_o.op = fra_pkg::OP_STRIP;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (status_i.gcd_done) begin
          cnt_d   = '0;
          state_d = S_DIVN;
        end else begin
          cmd_o.op = fra_pkg::OP_GCD;
        end
      end
      S_DIVN: begin
        cmd_o.op = fra_pkg::OP_DIVN;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd_o.op = fra_pkg::OP_DIVD;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);

`ifndef ASSERT_OFF
  // an accepted request always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("fra_ctrl: request accepted but block not busy");

  // the result strobe lasts exactly one cycle and then frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy))
    else $error("fra_ctrl: result strobe not a single cycle");

  // no gcd step is issued on operands that have already met
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == fra_pkg::OP_GCD) |-> !status_i.gcd_done)
    else $error("fra_ctrl: gcd step after convergence");

  // a result follows only a finished denominator division or an empty operand
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> ($past(state_q) == S_DIVD || status_i.empty))
    else $error("fra_ctrl: result without completed reduction");
`endif

endmodule

`default_nettype wire

@@ dv/tb_fraction_add_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_add_reduce
// Self-checking bench for the fraction adder. A table of directed requests
// (empty operands, extreme values, unreduced and even-heavy operands) runs
// first, then a long random phase weighted toward well-formed fractions with
// shared factors. Every accepted request is scored, in order and field by
// field, against its table literal or a behavioral gcd reduction of a*d + b*c over b*d.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fraction_add_reduce;

  localparam int unsigned VW            = fra_pkg::VALUE_BITS;
  localparam int unsigned NW            = fra_pkg::NUM_W;
  localparam int unsigned DW            = fra_pkg::DEN_W;
  localparam int          RANDOM_COUNT  = 1526;
  localparam int          QUIET_TAIL    = 200;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          CYCLE_LIMIT   = 1500000;

  typedef struct packed {
    logic [VW-1:0] lhs_num;
    logic [VW-1:0] lhs_den;
    logic [VW-1:0] rhs_num;
    logic [VW-1:0] rhs_den;
  } request_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    logic          empty;
  } sum_t;

  typedef struct packed {
    request_t req;
    logic     literal;
    sum_t     sum;
  } directed_row_t;

  localparam sum_t EMPTY_SUM = '{num: '0, den: '0, empty: 1'b1};

  // Directed table: literal rows carry their expected sum, the rest are
  // scored by the predictor.
  localparam int DIRECTED_COUNT = 24;
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{'{16'h0001, 16'h0001, 16'h0001, 16'h0001}, 1'b1, '{31'd2, 30'd1, 1'b0}},
    '{'{16'h0000, 16'h0001, 16'h0001, 16'h0001}, 1'b1, EMPTY_SUM},
    '{'{16'h0001, 16'h0000, 16'h0001, 16'h0001}, 1'b1, EMPTY_SUM},
    '{'{16'h0001, 16'h0001, 16'h0000, 16'h0001}, 1'b1, EMPTY_SUM},
    '{'{16'h0001, 16'h0001, 16'h0001, 16'h0000}, 1'b1, EMPTY_SUM},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1, EMPTY_SUM},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, EMPTY_SUM},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, '{31'd2, 30'd1, 1'b0}},
    '{'{16'h7FFF, 16'h0001, 16'h7FFF, 16'h0001}, 1'b1, '{31'd65534, 30'd1, 1'b0}},
    '{'{16'h0001, 16'h7FFF, 16'h0001, 16'h7FFF}, 1'b1, '{31'd2, 30'd32767, 1'b0}},
    '{'{16'h7FFF, 16'h0001, 16'h0001, 16'h7FFF}, 1'b0, '0},
    '{'{16'h0001, 16'h7FFF, 16'h7FFF, 16'h0001}, 1'b0, '0},
    '{'{16'h7FFF, 16'h7FFE, 16'h7FFF, 16'h7FFE}, 1'b0, '0},
    '{'{16'h0001, 16'h0002, 16'h0001, 16'h0003}, 1'b0, '0},
    '{'{16'h0002, 16'h0004, 16'h0003, 16'h0006}, 1'b1, '{31'd1, 30'd1, 1'b0}},
    '{'{16'h4000, 16'h4000, 16'h4000, 16'h4000}, 1'b1, '{31'd2, 30'd1, 1'b0}},
    '{'{16'h2000, 16'h4000, 16'h2000, 16'h4000}, 1'b1, '{31'd1, 30'd1, 1'b0}},
    '{'{16'h0001, 16'h7FFE, 16'h0001, 16'h7FFE}, 1'b0, '0},
    '{'{16'h7FFF, 16'hFFFF, 16'h0001, 16'h0001}, 1'b1, EMPTY_SUM},
    '{'{16'h8001, 16'h0001, 16'h0001, 16'h0001}, 1'b1, EMPTY_SUM},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, EMPTY_SUM},
    '{'{16'h7FFE, 16'h7FFF, 16'h7FFF, 16'h7FFE}, 1'b0, '0},
    '{'{16'h0001, 16'h0001, 16'h7FFF, 16'h7FFF}, 1'b1, '{31'd2, 30'd1, 1'b0}},
    '{'{16'h0003, 16'h0007, 16'h0005, 16'h000B}, 1'b0, '0}
  };

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [VW-1:0] lhs_numerator_i = '0;
  logic [VW-1:0] lhs_denominator_i = '0;
  logic [VW-1:0] rhs_numerator_i = '0;
  logic [VW-1:0] rhs_denominator_i = '0;
  logic          result_valid_o;
  logic [NW-1:0] sum_numerator_o;
  logic [DW-1:0] sum_denominator_o;
  logic          empty_result_o;

  // Literal expectation for the request on the ports, if the table gives one
  logic          use_literal = 1'b0;
  sum_t          literal_sum = '0;

  sum_t          expected_sums [$];
  int            error_count = 0;
  int            empty_seen = 0;
  int            reduced_seen = 0;
  int            cycle_count = 0;

  fraction_add_reduce dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .lhs_numerator_i   (lhs_numerator_i),
    .lhs_denominator_i (lhs_denominator_i),
    .rhs_numerator_i   (rhs_numerator_i),
    .rhs_denominator_i (rhs_denominator_i),
    .result_valid_o    (result_valid_o),
    .sum_numerator_o   (sum_numerator_o),
    .sum_denominator_o (sum_denominator_o),
    .empty_result_o    (empty_result_o)
  );

  always #6 clk_i = ~clk_i;

  // Magnitude of a strictly positive operand, zero otherwise
  function automatic longint unsigned positive_mag(logic [VW-1:0] raw);
    if (raw[VW-1]) begin
      return 0;
    end
    return longint'(raw);
  endfunction

  // Add two fractions and divide out the gcd
  function automatic sum_t reduce_sum(request_t r);
    longint unsigned a, b, c, d, n, q, x, y, t;
    sum_t s;
    a = positive_mag(r.lhs_num);
    b = positive_mag(r.lhs_den);
    c = positive_mag(r.rhs_num);
    d = positive_mag(r.rhs_den);
    if (a == 0 || b == 0 || c == 0 || d == 0) begin
      return EMPTY_SUM;
    end
    n = a * d + b * c;
    q = b * d;
    x = n;
    y = q;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    s.num   = NW'(n / x);
    s.den   = DW'(q / x);
    s.empty = 1'b0;
    return s;
  endfunction

  function automatic logic [VW-1:0] scaled_pick(int unsigned g);
    return VW'(g * $urandom_range(1, 32767 / g));
  endfunction

  // Build one random request; most are well-formed, the rest noise
  function automatic request_t random_request();
    request_t    r;
    int unsigned kind, g;
    logic [VW-1:0] bad;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      r = '{VW'($urandom_range(1, 255)), VW'($urandom_range(1, 255)),
            VW'($urandom_range(1, 255)), VW'($urandom_range(1, 255))};
    end else if (kind < 50) begin
      r = '{VW'($urandom_range(1, 32767)), VW'($urandom_range(1, 32767)),
            VW'($urandom_range(1, 32767)), VW'($urandom_range(1, 32767))};
    end else if (kind < 65) begin
      g = $urandom_range(2, 181);
      r = '{scaled_pick(g), scaled_pick(g), scaled_pick(g), scaled_pick(g)};
    end else if (kind < 75) begin
      r = '{VW'(1) << $urandom_range(0, 14), VW'(1) << $urandom_range(0, 14),
            VW'(1) << $urandom_range(0, 14), VW'(1) << $urandom_range(0, 14)};
    end else begin
      r = '{VW'($urandom), VW'($urandom), VW'($urandom), VW'($urandom)};
      // Force an empty operand on most noise requests
      if (kind < 95) begin
        bad = $urandom_range(0, 1) ? '0 : {1'b1, (VW-1)'($urandom)};
        case ($urandom_range(0, 3))
          0: r.lhs_num = bad;
          1: r.lhs_den = bad;
          2: r.rhs_num = bad;
          default: r.rhs_den = bad;
        endcase
      end
    end
    return r;
  endfunction

  // Idle length ahead of a request: random gaps, back-to-back stretches, back-to-back tail
  function automatic int idle_before(int index);
    if (index >= RANDOM_COUNT - QUIET_TAIL || (index / 100) % 3 == 2) begin
      return 0;
    end
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
  endfunction

  // Present one request at the falling edge and hold it until accepted
  task automatic send_request(input request_t r, input logic literal, input sum_t lit,
                              input int idle_cycles);
    if (idle_cycles > 0) begin
      start             = 1'b0;
      lhs_numerator_i   = VW'($urandom);
      lhs_denominator_i = VW'($urandom);
      rhs_numerator_i   = VW'($urandom);
      rhs_denominator_i = VW'($urandom);
      repeat (idle_cycles) @(negedge clk_i);
    end
    lhs_numerator_i   = r.lhs_num;
    lhs_denominator_i = r.lhs_den;
    rhs_numerator_i   = r.rhs_num;
    rhs_denominator_i = r.rhs_den;
    use_literal       = literal;
    literal_sum       = lit;
    start             = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Hold off new requests until every expected sum has come back
  task automatic drain_results();
    start = 1'b0;
    while (expected_sums.size() != 0) @(negedge clk_i);
  endtask

  // Score results and record accepted requests at the rising edge
  always @(posedge clk_i) begin
    sum_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result %0d/%0d empty=%0b", $realtime,
                   sum_numerator_o, sum_denominator_o, empty_result_o);
          error_count++;
        end else begin
          want = expected_sums.pop_front();
          if (sum_numerator_o !== want.num) begin
            $display("%0t: sum_numerator expected %0d actual %0d", $realtime,
                     want.num, sum_numerator_o);
            error_count++;
          end
          if (sum_denominator_o !== want.den) begin
            $display("%0t: sum_denominator expected %0d actual %0d", $realtime,
                     want.den, sum_denominator_o);
            error_count++;
          end
          if (empty_result_o !== want.empty) begin
            $display("%0t: empty_result expected %0b actual %0b", $realtime,
                     want.empty, empty_result_o);
            error_count++;
          end
          if (want.empty) empty_seen++;
          else reduced_seen++;
        end
      end
      if (start && !busy) begin
        expected_sums.push_back(use_literal ? literal_sum :
          reduce_sum('{lhs_numerator_i, lhs_denominator_i,
                       rhs_numerator_i, rhs_denominator_i}));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d sums still outstanding", $realtime,
               expected_sums.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].literal,
                   directed_rows[i].sum, (i % 5 == 4) ? $urandom_range(1, 14) : 0);
    end

    // Random requests; drain the pipeline now and then
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 500 == 250) drain_results();
      send_request(random_request(), 1'b0, '0, idle_before(i));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Scored %0d directed and %0d random requests: %0d reduced sums, %0d empty.",
             DIRECTED_COUNT, RANDOM_COUNT, reduced_seen, empty_seen);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
